/* rtl/sfp_pkg.sv */
package sfp_pkg;

  localparam int NUM_STARS_DEF = 64;
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int X_W      = $clog2(SCREEN_WIDTH);
  localparam int Y_W      = $clog2(SCREEN_HEIGHT);
  localparam int X_MID_SH = X_W - 1;
  localparam int Y_MID_SH = Y_W - 1;

  localparam int IDX_W      = 6;
  localparam int RAND_W     = 32;
  localparam int POS_W      = 8;
  localparam int DEPTH_W    = 8;
  localparam int ZW         = X_W;
  localparam int SPEED_W    = 4;
  localparam int GAIN_W     = 8;
  localparam int CFG_DATA_W = 8;

  localparam int NUM_W      = POS_W + GAIN_W + 2;
  localparam int MAG_W      = 16;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = MAG_W / DIV_BITS;

  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(3);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(75);

  typedef enum logic [0:0] {
    CFG_SPEED = 1'b0,
    CFG_GAIN  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]  star_index;
    logic [RAND_W-1:0] rand_x;
    logic [RAND_W-1:0] rand_y;
    logic [RAND_W-1:0] rand_z;
  } sfp_in_t;

  typedef struct packed {
    logic           visible;
    logic [X_W-1:0] pixel_x;
    logic [Y_W-1:0] pixel_y;
  } sfp_out_t;

  typedef struct packed {
    cfg_reg_e                index;
    logic [CFG_DATA_W-1:0]   value;
  } sfp_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [DEPTH_W-1:0] z;
  } star_t;

  typedef struct packed {
    logic             live;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [ZW-1:0]    z;
  } sfp_div_in_t;

  typedef struct packed {
    logic             live;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] q_x;
    logic [MAG_W-1:0] q_y;
  } sfp_div_out_t;

endpackage

/* rtl/sfp_stream_if.sv */
interface sfp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/sfp_star_table.sv */
module sfp_star_table import sfp_pkg::*; #(
  parameter int  NUM_STARS = NUM_STARS_DEF,
  localparam int AW        = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output star_t         rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  star_t         wr_data_i
);

  star_t                mem_q [NUM_STARS];
  logic [NUM_STARS-1:0] vld_q;
  star_t                rd_mem_q;
  star_t                fwd_q;
  logic                 rd_vld_q;
  logic                 fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_mem_q <= mem_q[rd_addr_i];
      fwd_q    <= wr_data_i;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_q : (rd_vld_q ? rd_mem_q : '0);

`ifndef SYNTHESIS
  a_fwd_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i) |=> rd_data_o == $past(wr_data_i))
    else $error("write on the read edge not forwarded");

  a_written_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> vld_q[$past(wr_addr_i)])
    else $error("written entry not marked valid");
`endif

endmodule

/* rtl/sfp_proj_div.sv */
module sfp_proj_div import sfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  sfp_div_in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output sfp_div_out_t out_data_o
);

  typedef struct packed {
    logic             live;
    logic             neg_x;
    logic             neg_y;
    logic [ZW-1:0]    z;
    logic [ZW-1:0]    rem_x;
    logic [ZW-1:0]    rem_y;
    logic [MAG_W-1:0] dq_x;
    logic [MAG_W-1:0] dq_y;
  } div_stage_t;

  // restoring division, quotient bits shift in where dividend bits leave
  function automatic div_stage_t div_steps(div_stage_t s);
    div_stage_t  r;
    logic [ZW:0] tx;
    logic [ZW:0] ty;
    r = s;
    for (int b = 0; b < DIV_BITS; b++) begin
      tx     = {r.rem_x, r.dq_x[MAG_W-1]};
      ty     = {r.rem_y, r.dq_y[MAG_W-1]};
      r.dq_x = {r.dq_x[MAG_W-2:0], 1'b0};
      r.dq_y = {r.dq_y[MAG_W-2:0], 1'b0};
      if (tx >= {1'b0, r.z}) begin
        tx        = tx - {1'b0, r.z};
        r.dq_x[0] = 1'b1;
      end
      if (ty >= {1'b0, r.z}) begin
        ty        = ty - {1'b0, r.z};
        r.dq_y[0] = 1'b1;
      end
      r.rem_x = tx[ZW-1:0];
      r.rem_y = ty[ZW-1:0];
    end
    return r;
  endfunction

  localparam int LAST = DIV_STAGES - 1;

  div_stage_t              stage_q  [DIV_STAGES];
  div_stage_t              step_in  [DIV_STAGES];
  div_stage_t              step_out [DIV_STAGES];
  logic [DIV_STAGES-1:0]   valid_q;
  logic [DIV_STAGES-1:0]   prev_v;
  logic [DIV_STAGES:0]     rdy;

  always_comb begin
    rdy[DIV_STAGES] = out_ready_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign prev_v = {valid_q[DIV_STAGES-2:0], in_valid_i};

  always_comb begin
    step_in[0].live  = in_data_i.live;
    step_in[0].neg_x = in_data_i.neg_x;
    step_in[0].neg_y = in_data_i.neg_y;
    step_in[0].z     = in_data_i.z;
    step_in[0].rem_x = '0;
    step_in[0].rem_y = '0;
    step_in[0].dq_x  = in_data_i.mag_x;
    step_in[0].dq_y  = in_data_i.mag_y;
    for (int k = 1; k < DIV_STAGES; k++) begin
      step_in[k] = stage_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      step_out[k] = div_steps(step_in[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= prev_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k] && prev_v[k]) begin
        stage_q[k] <= step_out[k];
      end
    end
  end

  assign in_ready_o       = rdy[0];
  assign out_valid_o      = valid_q[LAST];
  assign out_data_o.live  = stage_q[LAST].live;
  assign out_data_o.neg_x = stage_q[LAST].neg_x;
  assign out_data_o.neg_y = stage_q[LAST].neg_y;
  assign out_data_o.q_x   = stage_q[LAST].dq_x;
  assign out_data_o.q_y   = stage_q[LAST].dq_y;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LAST] && stage_q[LAST].live |->
      (stage_q[LAST].rem_x < stage_q[LAST].z) && (stage_q[LAST].rem_y < stage_q[LAST].z))
    else $error("division remainder not below divisor");
`endif

endmodule

/* rtl/starfield_projection_step.sv */
// Starfield projection: keeps a table of stars and, for each input beat,
// moves the named star toward the viewer and projects it onto the screen.
// in_if carries star_index and three random words (used only on respawn),
// out_if returns visible, pixel_x and pixel_y, one result beat per input.
// cfg_if writes speed (index 0) or focal_gain (index 1); it is always ready
// and must only be written while no item is in flight.
// An item passes stages 1 to 3, the divider and the result register; one
// item is taken every cycle while out_if is not stalled. The rate rests on
// the star table: a read port and a separate write port with a registered
// read, and a write on the same edge as a read of the same star is forwarded.
// The projection quotient comes from an 8-stage divider, two bits a stage.
// Reset clears the configuration to speed 3 and gain 75, and marks every
// star as zero through per-entry valid bits, so items are taken right away.
// When out_if stalls, the result register holds, the pipeline fills behind
// it and in_if ready drops once every stage holds an item.
module starfield_projection_step import sfp_pkg::*; #(
  parameter int NUM_STARS = NUM_STARS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  sfp_stream_if.sink   in_if,
  sfp_stream_if.source out_if,
  sfp_stream_if.sink   cfg_if
);

  localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

  // configuration
  logic [SPEED_W-1:0] speed_q;
  logic [GAIN_W-1:0]  gain_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
      gain_q  <= GAIN_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        CFG_SPEED: speed_q <= cfg_if.data.value[SPEED_W-1:0];
        CFG_GAIN:  gain_q  <= cfg_if.data.value[GAIN_W-1:0];
        default:   ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic div_in_ready, div_out_valid;
  logic in_fire;

  assign out_ready = !out_valid_q || out_if.ready;
  assign s3_ready  = !s3_valid_q || div_in_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign in_if.ready = s1_ready;
  assign in_fire   = in_if.valid && s1_ready;

  // stage 1: table read returns, update and write back
  logic           s1_in_range_q;
  logic [AW-1:0]  s1_addr_q;
  logic [X_W-1:0] s1_rx_q;
  logic [Y_W-1:0] s1_ry_q;
  logic [ZW-1:0]  s1_rz_q;

  star_t tbl_rd_data;
  star_t tbl_wr_data;
  logic  tbl_wr_en;

  logic signed [DEPTH_W:0] z_dec;
  logic                    respawn;

  sfp_star_table #(
    .NUM_STARS (NUM_STARS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (AW'(in_if.data.star_index)),
    .rd_data_o (tbl_rd_data),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (tbl_wr_data)
  );

  always_comb begin
    z_dec   = (DEPTH_W + 1)'(tbl_rd_data.z) - (DEPTH_W + 1)'({1'b0, speed_q});
    respawn = z_dec[DEPTH_W] || (z_dec == '0);
    if (respawn) begin
      tbl_wr_data.x = POS_W'(s1_rx_q) - POS_W'(SCREEN_WIDTH / 2);
      tbl_wr_data.y = POS_W'(s1_ry_q) - POS_W'(SCREEN_HEIGHT / 2);
      tbl_wr_data.z = DEPTH_W'(s1_rz_q);
    end else begin
      tbl_wr_data.x = tbl_rd_data.x;
      tbl_wr_data.y = tbl_rd_data.y;
      tbl_wr_data.z = z_dec[DEPTH_W-1:0];
    end
  end

  assign tbl_wr_en = s1_valid_q && s2_ready && s1_in_range_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_in_range_q <= 32'(in_if.data.star_index) < NUM_STARS;
      s1_addr_q     <= AW'(in_if.data.star_index);
      s1_rx_q       <= in_if.data.rand_x[X_W-1:0];
      s1_ry_q       <= in_if.data.rand_y[Y_W-1:0];
      s1_rz_q       <= in_if.data.rand_z[ZW-1:0];
    end
  end

  // stage 2: updated star
  logic  s2_in_range_q;
  star_t s2_star_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_in_range_q <= s1_in_range_q;
      s2_star_q     <= tbl_wr_data;
    end
  end

  // stage 3: numerators, sign and magnitude for the divider
  logic signed [POS_W+GAIN_W:0] prod_x, prod_y;
  logic        [NUM_W-1:0]      num_x, num_y;
  logic        [ZW-1:0]         z_u;
  sfp_div_in_t                  div_in_d;
  sfp_div_in_t                  s3_div_q;

  always_comb begin
    z_u    = s2_star_q.z[ZW-1:0];
    prod_x = s2_star_q.x * $signed({1'b0, gain_q});
    prod_y = s2_star_q.y * $signed({1'b0, gain_q});
    num_x  = NUM_W'(prod_x) + (NUM_W'(z_u) << X_MID_SH);
    num_y  = NUM_W'(prod_y) + (NUM_W'(z_u) << Y_MID_SH);
    div_in_d.live  = s2_in_range_q && (s2_star_q.z != '0);
    div_in_d.neg_x = num_x[NUM_W-1];
    div_in_d.neg_y = num_y[NUM_W-1];
    div_in_d.mag_x = num_x[NUM_W-1] ? MAG_W'(-num_x) : MAG_W'(num_x);
    div_in_d.mag_y = num_y[NUM_W-1] ? MAG_W'(-num_y) : MAG_W'(num_y);
    div_in_d.z     = z_u;
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      s3_div_q <= div_in_d;
    end
  end

  sfp_div_out_t div_out;

  sfp_proj_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_valid_q),
    .in_ready_o  (div_in_ready),
    .in_data_i   (s3_div_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (div_out)
  );

  // result register
  logic     vis_x, vis_y;
  sfp_out_t out_d;
  sfp_out_t out_q;

  always_comb begin
    // truncation toward zero: a negative numerator lands on column 0 only when |num| < z
    vis_x = div_out.neg_x ? (div_out.q_x == '0) : (div_out.q_x < MAG_W'(SCREEN_WIDTH));
    vis_y = div_out.neg_y ? (div_out.q_y == '0) : (div_out.q_y < MAG_W'(SCREEN_HEIGHT));
    out_d.visible = div_out.live && vis_x && vis_y;
    out_d.pixel_x = (out_d.visible && !div_out.neg_x) ? div_out.q_x[X_W-1:0] : '0;
    out_d.pixel_y = (out_d.visible && !div_out.neg_y) ? div_out.q_y[Y_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (div_out_valid && out_ready) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_if.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= div_out_valid;
      end
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> s1_valid_q && s2_valid_q && s3_valid_q)
    else $error("input stalled with an empty front stage");

  a_depth_stored_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr_en |-> !tbl_wr_data.z[DEPTH_W-1])
    else $error("negative depth written to star table");

  a_hidden_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.data.visible |->
      (out_if.data.pixel_x == '0) && (out_if.data.pixel_y == '0))
    else $error("hidden result carries a nonzero pixel");
`endif

endmodule

/* verif/tb_starfield_projection_step.sv */
`timescale 1ns / 100ps

module tb_starfield_projection_step;
  import sfp_pkg::*;

  localparam int N_STARS       = NUM_STARS_DEF;
  localparam int DRAIN_GAP     = 16;
  localparam int STALL_CYCLES  = 64;
  localparam int PHASE_ITEMS   = 190;
  localparam int PHASES        = 6;

  typedef enum logic [0:0] {
    ROW_STAR,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    sfp_in_t   beat;
    cfg_reg_e  reg_sel;
    int        value;
    bit        typed;
    sfp_out_t  want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sfp_stream_if #(.T(sfp_in_t))  in_if ();
  sfp_stream_if #(.T(sfp_out_t)) out_if ();
  sfp_stream_if #(.T(sfp_cfg_t)) cfg_if ();

  starfield_projection_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // shadow star table and registers
  int pos_x_tbl [N_STARS];
  int pos_y_tbl [N_STARS];
  int depth_tbl [N_STARS];
  int cur_speed;
  int cur_gain;

  sfp_out_t pending_pixels [$];

  int  mismatches;
  int  beats_checked;
  int  visible_seen;
  int  stars_sent;
  int  respawns;
  int  reg_writes;
  bit  calm;

  // directed rows; typed expectations where the answer is obvious
  dir_row_t dir_rows [23] = '{
    // fresh table, all-zero words: respawn at depth zero
    '{ROW_STAR, '{6'd0, 32'h0, 32'h0, 32'h0}, CFG_SPEED, 0, 1'b1, '{1'b0, 7'd0, 6'd0}},
    // respawn at the axis origin lands on screen center
    '{ROW_STAR, '{6'd1, 32'd64, 32'd32, 32'd64}, CFG_SPEED, 0, 1'b1, '{1'b1, 7'd64, 6'd32}},
    '{ROW_STAR, '{6'd63, '1, '1, '1}, CFG_SPEED, 0, 1'b0, '0},
    // no respawn, random words ignored
    '{ROW_STAR, '{6'd1, '1, '1, '1}, CFG_SPEED, 0, 1'b1, '{1'b1, 7'd64, 6'd32}},
    // corner at depth one is far off screen
    '{ROW_STAR, '{6'd2, 32'h0, 32'h0, 32'd1}, CFG_SPEED, 0, 1'b1, '{1'b0, 7'd0, 6'd0}},
    '{ROW_STAR, '{6'd2, 32'h7f, 32'h3f, 32'hffffff7f}, CFG_SPEED, 0, 1'b0, '0},
    '{ROW_STAR, '{6'd3, 32'h80000000, 32'hffffffc0, 32'h41}, CFG_SPEED, 0, 1'b0, '0},
    '{ROW_CFG, '0, CFG_SPEED, 15, 1'b0, '0},
    '{ROW_STAR, '{6'd1, 32'h0, 32'h0, 32'h0}, CFG_SPEED, 0, 1'b1, '{1'b1, 7'd64, 6'd32}},
    '{ROW_STAR, '{6'd4, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9}, CFG_SPEED, 0, 1'b0, '0},
    '{ROW_CFG, '0, CFG_GAIN, 255, 1'b0, '0},
    '{ROW_STAR, '{6'd63, 32'h0, 32'h0, 32'h0}, CFG_SPEED, 0, 1'b0, '0},
    // zero gain: everything collapses onto the center
    '{ROW_CFG, '0, CFG_GAIN, 0, 1'b0, '0},
    '{ROW_STAR, '{6'd63, 32'h0, 32'h0, 32'h0}, CFG_SPEED, 0, 1'b1, '{1'b1, 7'd64, 6'd32}},
    // zero speed: a star at depth zero still respawns
    '{ROW_CFG, '0, CFG_SPEED, 0, 1'b0, '0},
    '{ROW_STAR, '{6'd0, 32'h55555555, 32'haaaaaaaa, 32'd5}, CFG_SPEED, 0, 1'b1,
      '{1'b1, 7'd64, 6'd32}},
    '{ROW_STAR, '{6'd1, '1, '1, '1}, CFG_SPEED, 0, 1'b1, '{1'b1, 7'd64, 6'd32}},
    '{ROW_CFG, '0, CFG_SPEED, 1, 1'b0, '0},
    '{ROW_CFG, '0, CFG_GAIN, 1, 1'b0, '0},
    '{ROW_STAR, '{6'd5, 32'hffffffff, 32'h0, 32'h7f}, CFG_SPEED, 0, 1'b0, '0},
    '{ROW_STAR, '{6'd2, 32'h0, 32'h0, 32'h0}, CFG_SPEED, 0, 1'b0, '0},
    '{ROW_CFG, '0, CFG_SPEED, 3, 1'b0, '0},
    '{ROW_CFG, '0, CFG_GAIN, 75, 1'b0, '0}
  };

  always #10 clk_i = ~clk_i;

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // moves one star toward the viewer and projects it, updating the shadow table
  function automatic sfp_out_t advance_and_project(sfp_in_t beat);
    int idx, z, px, py;
    sfp_out_t res;
    res = '0;
    idx = int'(beat.star_index);
    if (idx >= N_STARS) return res;
    z = depth_tbl[idx] - cur_speed;
    if (z <= 0) begin
      pos_x_tbl[idx] = int'(beat.rand_x % 32'(SCREEN_WIDTH)) - SCREEN_WIDTH / 2;
      pos_y_tbl[idx] = int'(beat.rand_y % 32'(SCREEN_HEIGHT)) - SCREEN_HEIGHT / 2;
      z = int'(beat.rand_z % 32'(SCREEN_WIDTH));
      respawns++;
    end
    depth_tbl[idx] = z;
    if (z == 0) return res;
    // int division truncates toward zero
    px = (pos_x_tbl[idx] * cur_gain + (SCREEN_WIDTH / 2) * z) / z;
    py = (pos_y_tbl[idx] * cur_gain + (SCREEN_HEIGHT / 2) * z) / z;
    if (px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT) begin
      res.visible = 1'b1;
      res.pixel_x = X_W'(px);
      res.pixel_y = Y_W'(py);
    end
    return res;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_star(sfp_in_t beat, bit typed, sfp_out_t want);
    sfp_out_t predicted;
    in_if.valid <= 1'b1;
    in_if.data  <= beat;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = advance_and_project(beat);
    pending_pixels.push_back(typed ? want : predicted);
    stars_sent++;
    @(negedge clk_i);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e sel, int value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= sfp_cfg_t'{sel, CFG_DATA_W'(value)};
    do @(posedge clk_i); while (!cfg_if.ready);
    if (sel == CFG_SPEED) cur_speed = value & 'hf;
    else cur_gain = value & 'hff;
    reg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic sfp_in_t random_star();
    sfp_in_t beat;
    // half the traffic hits a few stars so they fall through and respawn often
    beat.star_index = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 7))
                                           : IDX_W'($urandom_range(0, N_STARS - 1));
    beat.rand_x = $urandom;
    beat.rand_y = $urandom;
    beat.rand_z = $urandom;
    // shallow respawns: depth zero and far off-screen corners
    if ($urandom_range(0, 7) == 0)
      beat.rand_z = (beat.rand_z & ~32'h7f) | 32'($urandom_range(0, 3));
    return beat;
  endfunction

  always @(posedge clk_i) begin : pixel_checker
    sfp_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_checked++;
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with nothing expected: visible %0d x %0d y %0d",
               out_if.data.visible, out_if.data.pixel_x, out_if.data.pixel_y);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (want.visible) visible_seen++;
        if (out_if.data.visible !== want.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, out_if.data.visible);
          mismatches++;
        end
        if (out_if.data.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_if.data.pixel_x);
          mismatches++;
        end
        if (out_if.data.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_if.data.pixel_y);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_sink
    int  idle_left;
    bit  stall_done;
    idle_left    = 0;
    stall_done   = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!stall_done && beats_checked >= 150) begin
        // long hold-off so the pipeline fills and input ready drops
        out_if.ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk_i);
        stall_done = 1'b1;
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else if (idle_left > 0) begin
        out_if.ready <= 1'b0;
        idle_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        idle_left = $urandom_range(1, 8) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int speed_v, gain_v;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    calm          = 1'b0;
    mismatches    = 0;
    beats_checked = 0;
    visible_seen  = 0;
    stars_sent    = 0;
    respawns      = 0;
    reg_writes    = 0;
    cur_speed     = int'(SPEED_RESET);
    cur_gain      = int'(GAIN_RESET);
    for (int i = 0; i < N_STARS; i++) begin
      pos_x_tbl[i] = 0;
      pos_y_tbl[i] = 0;
      depth_tbl[i] = 0;
    end

    @(posedge rst_ni);
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[r].reg_sel, dir_rows[r].value);
      end else begin
        send_star(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin speed_v = 3;  gain_v = 75;  end
        1: begin speed_v = 15; gain_v = 255; end
        2: begin speed_v = 1;  gain_v = 1;   end
        default: begin
          speed_v = $urandom_range(1, 15);
          gain_v  = $urandom_range(0, 255);
        end
      endcase
      wait_idle();
      write_reg(CFG_SPEED, speed_v);
      write_reg(CFG_GAIN, gain_v);
      calm = (p == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        maybe_pause();
        send_star(random_star(), 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $error("%0d pixel beats never arrived", pending_pixels.size());
      mismatches++;
    end

    $display("sent %0d star updates over %0d register writes, %0d respawns",
             stars_sent, reg_writes, respawns);
    $display("checked %0d pixel beats, %0d on screen, %0d mismatches",
             beats_checked, visible_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sfp_pkg.sv
rtl/sfp_stream_if.sv
rtl/sfp_star_table.sv
rtl/sfp_proj_div.sv
rtl/starfield_projection_step.sv
verif/tb_starfield_projection_step.sv
